[hw/rtl/ptw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants for the triclinic periodic wrap
// Channel payloads, the pipeline item, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int LEN_W      = 31;  // edge length, unsigned Q15.16
  localparam int ACC_W      = 44;  // wide per-axis accumulator
  localparam int TERM_W     = 42;  // signed lattice term, clamped to +-2^40
  localparam int DIV_STAGES = 33;  // one quotient bit per stage, 33-bit dividend

  localparam logic [LEN_W-1:0]  LEN_RESET  = 31'h0001_0000;
  localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
  localparam logic [TERM_W-2:0] TERM_LIMIT = 41'h100_0000_0000;
  localparam logic [1:0]        OBUF_FULL  = 2'd2;

  typedef enum logic {
    OP_MIN_IMAGE = 1'b0,
    OP_SHIFT     = 1'b1
  } ptw_op_t;

  typedef enum logic [2:0] {
    CFG_LENGTH_X = 3'd0,
    CFG_LENGTH_Y = 3'd1,
    CFG_LENGTH_Z = 3'd2,
    CFG_TILT_XY  = 3'd3,
    CFG_TILT_XZ  = 3'd4,
    CFG_TILT_YZ  = 3'd5
  } ptw_cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } ptw_axis_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] image_x;
    logic signed [15:0] image_y;
    logic signed [15:0] image_z;
  } ptw_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } ptw_out_t;

  // item as it travels down the pipeline
  typedef struct packed {
    ptw_op_t                 op;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
    logic signed [15:0]      image_x;
    logic signed [15:0]      image_y;
    logic signed [15:0]      image_z;
    logic                    sat;
  } ptw_item_t;

  function automatic logic ovf32(input logic [ACC_W-1:0] v);
    return !((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]));
  endfunction

  function automatic logic [31:0] sat32(input logic [ACC_W-1:0] v);
    if (ovf32(v)) begin
      return v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  function automatic logic [ACC_W-1:0] sext_acc(input logic [31:0] v);
    return {{(ACC_W-32){v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ptw_term.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_term: lattice term unit
// len * tilt * count / 2^16, truncated toward zero, clamped to +-2^40.
// Three register stages, advancing on en.
// ----------------------------------------------------------------------------
module ptw_term (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ptw_pkg::LEN_W-1:0]         len,
  input  logic signed [31:0]                tilt,
  input  logic [31:0]                       cnt_mag,
  input  logic                              cnt_neg,
  output logic signed [ptw_pkg::TERM_W-1:0] term
);
  import ptw_pkg::*;

  logic [31:0]       tilt_mag;
  logic [62:0]       ab_r;
  logic [31:0]       c_r;
  logic              neg1_r;
  logic [62:0]       hc_r;
  logic [63:0]       lo_r;
  logic              neg2_r;
  logic [48:0]       sum;
  logic [TERM_W-2:0] mag;
  logic [TERM_W-1:0] term_nxt;
  logic [TERM_W-1:0] term_r;

  assign tilt_mag = tilt[31] ? (~tilt + 32'd1) : tilt;

  // stage 1: len * |tilt|
  always_ff @(posedge clk) begin
    if (en) begin
      ab_r   <= {32'd0, len} * {31'd0, tilt_mag};
      c_r    <= cnt_mag;
      neg1_r <= tilt[31] ^ cnt_neg;
    end
  end

  // stage 2: split the 63-bit product into two 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hc_r   <= {32'd0, ab_r[62:32]} * {31'd0, c_r};
      lo_r   <= {32'd0, ab_r[31:0]} * {32'd0, c_r};
      neg2_r <= neg1_r;
    end
  end

  // stage 3: recombine, clamp, apply sign
  always_comb begin
    sum = {9'd0, hc_r[23:0], 16'd0} + {1'b0, lo_r[63:16]};
    if ((|hc_r[62:24]) || (sum > {8'd0, TERM_LIMIT})) begin
      mag = TERM_LIMIT;
    end else begin
      mag = sum[TERM_W-2:0];
    end
    term_nxt = neg2_r ? (~{1'b0, mag} + 42'd1) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule
`default_nettype wire

[hw/rtl/ptw_fold.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptw_fold: one axis step
// Image count by a bit-per-stage divider, then lattice terms and the update
// of all three accumulators. 39 register stages, advancing on en.
// ----------------------------------------------------------------------------
module ptw_fold (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  ptw_pkg::ptw_axis_t        axis,
  input  logic [ptw_pkg::LEN_W-1:0] len,
  input  logic signed [31:0]        tilt_a,
  input  logic signed [31:0]        tilt_b,
  input  logic                      valid_i,
  input  ptw_pkg::ptw_item_t        item_i,
  output logic                      valid_o,
  output ptw_pkg::ptw_item_t        item_o
);
  import ptw_pkg::*;

  logic [31:0] key;
  logic [31:0] key_mag;
  logic [32:0] num_in;
  logic [31:0] den;

  logic        valid_r [DIV_STAGES+1];
  ptw_item_t   item_r  [DIV_STAGES+1];
  logic [32:0] num_r   [DIV_STAGES+1];
  logic [31:0] rem_r   [DIV_STAGES+1];
  logic [31:0] quo_r   [DIV_STAGES+1];
  logic        neg_r   [DIV_STAGES+1];

  ptw_item_t   last;
  logic [15:0] img;
  logic [15:0] img_mag;
  logic        cvalid_r;
  ptw_item_t   citem_r;
  logic [31:0] cmag_r;
  logic        cneg_r;

  logic signed [TERM_W-1:0] term0, term1, term2;
  logic                     dvalid_r [3];
  ptw_item_t                ditem_r  [3];

  ptw_item_t        it;
  logic [ACC_W-1:0] t0e, t1e, t2e;
  logic [ACC_W-1:0] dx, dy, dz;
  logic [ACC_W-1:0] sx, sy, sz;
  ptw_item_t        item_o_nxt;
  logic             valid_o_r;
  ptw_item_t        item_o_r;

  // dividend 2|v| + len, divisor 2 len: round half away from zero
  always_comb begin
    case (axis)
      AXIS_X:  key = item_i.x[31:0];
      AXIS_Y:  key = item_i.y[31:0];
      AXIS_Z:  key = item_i.z[31:0];
      default: key = item_i.x[31:0];
    endcase
    key_mag = key[31] ? (~key + 32'd1) : key;
    num_in  = {key_mag, 1'b0} + {2'b00, len};
    den     = {len, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= item_i;
      num_r[0]  <= num_in;
      rem_r[0]  <= '0;
      quo_r[0]  <= '0;
      neg_r[0]  <= key[31];
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_r[k], num_r[k][32]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item_r[k+1] <= item_r[k];
        num_r[k+1]  <= {num_r[k][31:0], 1'b0};
        rem_r[k+1]  <= ge ? diff[31:0] : trial[31:0];
        quo_r[k+1]  <= {quo_r[k][30:0], ge};
        neg_r[k+1]  <= neg_r[k];
      end
    end
  end

  // count select: divided count, or the given image count for a shift
  assign last = item_r[DIV_STAGES];

  always_comb begin
    case (axis)
      AXIS_X:  img = last.image_x;
      AXIS_Y:  img = last.image_y;
      AXIS_Z:  img = last.image_z;
      default: img = last.image_x;
    endcase
    img_mag = img[15] ? (~img + 16'd1) : img;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= 1'b0;
    end else if (en) begin
      cvalid_r <= valid_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      citem_r <= last;
      if (last.op == OP_SHIFT) begin
        cmag_r <= {16'd0, img_mag};
        cneg_r <= img[15];
      end else begin
        cmag_r <= (len == '0) ? '0 : quo_r[DIV_STAGES];
        cneg_r <= neg_r[DIV_STAGES];
      end
    end
  end

  ptw_term u_term0 (
    .clk     (clk),
    .en      (en),
    .len     (len),
    .tilt    (Q_ONE),
    .cnt_mag (cmag_r),
    .cnt_neg (cneg_r),
    .term    (term0)
  );

  ptw_term u_term1 (
    .clk     (clk),
    .en      (en),
    .len     (len),
    .tilt    (tilt_a),
    .cnt_mag (cmag_r),
    .cnt_neg (cneg_r),
    .term    (term1)
  );

  ptw_term u_term2 (
    .clk     (clk),
    .en      (en),
    .len     (len),
    .tilt    (tilt_b),
    .cnt_mag (cmag_r),
    .cnt_neg (cneg_r),
    .term    (term2)
  );

  // item rides alongside the term units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r[0] <= 1'b0;
      dvalid_r[1] <= 1'b0;
      dvalid_r[2] <= 1'b0;
    end else if (en) begin
      dvalid_r[0] <= cvalid_r;
      dvalid_r[1] <= dvalid_r[0];
      dvalid_r[2] <= dvalid_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ditem_r[0] <= citem_r;
      ditem_r[1] <= ditem_r[0];
      ditem_r[2] <= ditem_r[1];
    end
  end

  // update: min image subtracts and saturates per step, shift adds wide
  always_comb begin
    it  = ditem_r[2];
    t0e = {{(ACC_W-TERM_W){term0[TERM_W-1]}}, term0};
    t1e = {{(ACC_W-TERM_W){term1[TERM_W-1]}}, term1};
    t2e = {{(ACC_W-TERM_W){term2[TERM_W-1]}}, term2};
    case (axis)
      AXIS_Z: begin
        dz = t0e;
        dy = t1e;
        dx = t2e;
      end
      AXIS_Y: begin
        dz = '0;
        dy = t0e;
        dx = t1e;
      end
      AXIS_X: begin
        dz = '0;
        dy = '0;
        dx = t0e;
      end
      default: begin
        dz = '0;
        dy = '0;
        dx = t0e;
      end
    endcase
    item_o_nxt = it;
    if (it.op == OP_SHIFT) begin
      sx = it.x + dx;
      sy = it.y + dy;
      sz = it.z + dz;
      item_o_nxt.x = sx;
      item_o_nxt.y = sy;
      item_o_nxt.z = sz;
    end else begin
      sx = it.x - dx;
      sy = it.y - dy;
      sz = it.z - dz;
      item_o_nxt.x   = sext_acc(sat32(sx));
      item_o_nxt.y   = sext_acc(sat32(sy));
      item_o_nxt.z   = sext_acc(sat32(sz));
      item_o_nxt.sat = it.sat | ovf32(sx) | ovf32(sy) | ovf32(sz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o_r <= 1'b0;
    end else if (en) begin
      valid_o_r <= dvalid_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_o_r <= item_o_nxt;
    end
  end

  assign valid_o = valid_o_r;
  assign item_o  = item_o_r;

endmodule
`default_nettype wire

[hw/rtl/triclinic_periodic_wrap.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triclinic_periodic_wrap: periodic-boundary unit for a triclinic box
// Minimum image of a vector, or shift of a position by image counts, in Q16.16.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   in_      | request   | in_valid / in_stall   | ptw_in_t  (op, vector, images)
//   out_     | result    | out_valid / out_stall | ptw_out_t (vector, saturated)
//   cfg_     | write     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle while in_stall is low. A request passes three axis
// steps (z, y, x) of 39 stages each, dominated by the 33-stage divider that
// forms each image count one quotient bit per stage. The final saturation
// is combinational into the output buffer write.
// Synchronous active-low reset clears the valid bits and loads the box
// registers with unit edges and zero tilt.
// The pipeline moves as a whole; a 2-entry output buffer absorbs out_stall,
// and in_stall rises only when both entries are held.
// User must keep box registers static while requests are in flight: not enforced.
// ----------------------------------------------------------------------------
module triclinic_periodic_wrap (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  ptw_pkg::ptw_in_t  in_data,

  output logic              out_valid,
  input  logic              out_stall,
  output ptw_pkg::ptw_out_t out_data,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import ptw_pkg::*;

  // box registers
  logic [LEN_W-1:0]   length_x_r, length_y_r, length_z_r;
  logic signed [31:0] tilt_xy_r, tilt_xz_r, tilt_yz_r;

  // pipeline control: everything advances together while the buffer has room
  logic      pipe_en;
  logic      in_accept;
  ptw_item_t in_item;

  logic      zv, yv, xv;
  ptw_item_t zi, yi, xi;

  // output buffer
  ptw_out_t   res;
  logic       push, pop;
  logic [1:0] cnt_r, cnt_nxt;
  ptw_out_t   slot0_r, slot0_nxt;
  ptw_out_t   slot1_r, slot1_nxt;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_x_r <= LEN_RESET;
      length_y_r <= LEN_RESET;
      length_z_r <= LEN_RESET;
      tilt_xy_r  <= '0;
      tilt_xz_r  <= '0;
      tilt_yz_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LENGTH_X: length_x_r <= cfg_data[LEN_W-1:0];
        CFG_LENGTH_Y: length_y_r <= cfg_data[LEN_W-1:0];
        CFG_LENGTH_Z: length_z_r <= cfg_data[LEN_W-1:0];
        CFG_TILT_XY:  tilt_xy_r  <= cfg_data;
        CFG_TILT_XZ:  tilt_xz_r  <= cfg_data;
        CFG_TILT_YZ:  tilt_yz_r  <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- input ----------------
  assign in_stall  = (cnt_r == OBUF_FULL);
  assign pipe_en   = !in_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_item         = '0;
    in_item.op      = ptw_op_t'(in_data.operation);
    in_item.x       = sext_acc(in_data.vec_x);
    in_item.y       = sext_acc(in_data.vec_y);
    in_item.z       = sext_acc(in_data.vec_z);
    in_item.image_x = in_data.image_x;
    in_item.image_y = in_data.image_y;
    in_item.image_z = in_data.image_z;
    in_item.sat     = 1'b0;
  end

  // ---------------- axis steps ----------------
  // z step: folds z, carries the yz and xz tilt into y and x
  ptw_fold u_fold_z (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .axis    (AXIS_Z),
    .len     (length_z_r),
    .tilt_a  (tilt_yz_r),
    .tilt_b  (tilt_xz_r),
    .valid_i (in_accept),
    .item_i  (in_item),
    .valid_o (zv),
    .item_o  (zi)
  );

  // y step: folds the updated y, carries the xy tilt into x
  ptw_fold u_fold_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .axis    (AXIS_Y),
    .len     (length_y_r),
    .tilt_a  (tilt_xy_r),
    .tilt_b  ('0),
    .valid_i (zv),
    .item_i  (zi),
    .valid_o (yv),
    .item_o  (yi)
  );

  // x step: x edge has no tilt
  ptw_fold u_fold_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .axis    (AXIS_X),
    .len     (length_x_r),
    .tilt_a  ('0),
    .tilt_b  ('0),
    .valid_i (yv),
    .item_i  (yi),
    .valid_o (xv),
    .item_o  (xi)
  );

  // ---------------- final saturation ----------------
  // shift sums are still wide here; min image values are already in range
  always_comb begin
    res.out_x     = sat32(xi.x);
    res.out_y     = sat32(xi.y);
    res.out_z     = sat32(xi.z);
    res.saturated = xi.sat | ovf32(xi.x) | ovf32(xi.y) | ovf32(xi.z);
  end

  // ---------------- output buffer ----------------
  assign push = xv && pipe_en;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          slot0_nxt = res;
        end else begin
          slot1_nxt = res;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        cnt_nxt   = cnt_r - 2'd1;
      end
      2'b11: begin
        // push only happens below full, so one entry is held here
        slot0_nxt = res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

endmodule
`default_nettype wire
